// File: rtl/dbh_pkg.sv
// Shared types and constants for the dual byte hash block.
`timescale 1ns / 1ps

package dbh_pkg;

    localparam logic [31:0] MUR_MUL    = 32'h5bd1e995;
    localparam logic [31:0] SEED_RESET = 32'hF835E195;

    // Commands from the controller to the datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_MUL_K,
        CMD_MUL_K2,
        CMD_MUL_ACC,
        CMD_MIX_DONE,
        CMD_TAIL,
        CMD_FIN,
        CMD_OUT
    } t_cmd;

    // Status of the byte being accepted, valid in the accept cycle
    typedef struct packed {
        logic empty;      // first byte of a key of length zero
        logic word_done;  // byte completes a 4-byte word
        logic last;       // byte ends the key
    } t_status;

endpackage

// File: rtl/dbh_if.sv
// Valid/ready channel interfaces for key bytes and hash results.
`timescale 1ns / 1ps

interface dbh_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [31:0] key_length;

    modport source(output valid, output byte_value, output key_length, input ready);
    modport sink(input valid, input byte_value, input key_length, output ready);
endinterface

interface dbh_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source(output valid, output hash_value, input ready);
    modport sink(input valid, input hash_value, output ready);
endinterface

// File: rtl/dbh_datapath.sv
// Datapath: hash accumulators, word assembly, shared constant multiplier, result register.
`timescale 1ns / 1ps

module dbh_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [31:0]     i_cfg_wr_data,
    input  dbh_pkg::t_cmd   i_cmd,
    input  logic [7:0]      i_byte,
    input  logic [31:0]     i_len,
    output dbh_pkg::t_status o_status,
    output logic [63:0]     o_hash
);

    logic [31:0] r_seed;
    logic [31:0] r_macc;
    logic [31:0] r_jacc;
    logic [23:0] r_word;
    logic [1:0]  r_phase;
    logic [31:0] r_left;
    logic        r_in_key;
    logic [31:0] r_k;
    logic [31:0] r_prod;
    logic [63:0] r_hash;

    logic [31:0] macc_cur;
    logic [31:0] jacc_cur;
    logic [23:0] word_cur;
    logic [1:0]  phase_cur;
    logic [31:0] left_cur;
    logic [23:0] word_ins;
    logic [31:0] mul_op;
    logic [31:0] mul_out;

    function automatic logic [31:0] jenkins_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] h;
        h = acc + {24'd0, b};
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    function automatic logic [31:0] jenkins_final(input logic [31:0] acc);
        logic [31:0] h;
        h = acc + (acc << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    // First byte of a key starts from fresh state
    always_comb begin
        if (r_in_key) begin
            macc_cur  = r_macc;
            jacc_cur  = r_jacc;
            word_cur  = r_word;
            phase_cur = r_phase;
            left_cur  = r_left;
        end else begin
            macc_cur  = r_seed ^ i_len;
            jacc_cur  = 32'd0;
            word_cur  = 24'd0;
            phase_cur = 2'd0;
            left_cur  = i_len;
        end
    end

    always_comb begin
        unique case (phase_cur)
            2'd0:    word_ins = {16'd0, i_byte};
            2'd1:    word_ins = {8'd0, i_byte, 8'd0};
            2'd2:    word_ins = {i_byte, 16'd0};
            default: word_ins = 24'd0;
        endcase
    end

    assign o_status.empty     = !r_in_key && (i_len == 32'd0);
    assign o_status.word_done = (phase_cur == 2'd3);
    assign o_status.last      = (left_cur == 32'd1);

    always_comb begin
        unique case (i_cmd)
            dbh_pkg::CMD_MUL_K:   mul_op = r_k;
            dbh_pkg::CMD_MUL_K2:  mul_op = r_prod ^ (r_prod >> 24);
            dbh_pkg::CMD_MUL_ACC: mul_op = r_macc;
            dbh_pkg::CMD_TAIL:    mul_op = r_macc ^ {8'd0, r_word};
            dbh_pkg::CMD_FIN:     mul_op = r_prod ^ (r_prod >> 13);
            default:              mul_op = r_macc;
        endcase
    end

    assign mul_out = mul_op * dbh_pkg::MUR_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= dbh_pkg::SEED_RESET;
            r_phase  <= 2'd0;
            r_in_key <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            unique case (i_cmd)
                dbh_pkg::CMD_ACCEPT: begin
                    if (o_status.empty) begin
                        r_macc  <= r_seed;
                        r_jacc  <= 32'd0;
                        r_word  <= 24'd0;
                        r_phase <= 2'd0;
                    end else begin
                        r_jacc   <= jenkins_step(jacc_cur, i_byte);
                        r_macc   <= macc_cur;
                        r_left   <= left_cur - 32'd1;
                        r_in_key <= 1'b1;
                        if (o_status.word_done) begin
                            r_k     <= {i_byte, word_cur};
                            r_word  <= 24'd0;
                            r_phase <= 2'd0;
                        end else begin
                            r_word  <= word_cur | word_ins;
                            r_phase <= phase_cur + 2'd1;
                        end
                    end
                end
                dbh_pkg::CMD_MUL_K,
                dbh_pkg::CMD_MUL_K2,
                dbh_pkg::CMD_FIN: begin
                    r_prod <= mul_out;
                end
                dbh_pkg::CMD_MUL_ACC: begin
                    r_k    <= r_prod;
                    r_prod <= mul_out;
                end
                dbh_pkg::CMD_MIX_DONE: begin
                    r_macc <= r_prod ^ r_k;
                end
                dbh_pkg::CMD_TAIL: begin
                    r_prod <= (r_phase != 2'd0) ? mul_out : r_macc;
                    r_jacc <= jenkins_final(r_jacc);
                end
                dbh_pkg::CMD_OUT: begin
                    r_hash   <= {r_jacc, r_prod ^ (r_prod >> 15)};
                    r_in_key <= 1'b0;
                    r_phase  <= 2'd0;
                    r_word   <= 24'd0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_hash = r_hash;

endmodule

// File: rtl/dbh_ctrl.sv
// Controller: sequences byte intake, word mixing, finalization and result handoff.
`timescale 1ns / 1ps

module dbh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  dbh_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output dbh_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_MIX3,
        S_MIX4,
        S_TAIL,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_last;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = o_in_ready && i_in_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        unique case (r_state)
            S_IDLE:  o_cmd = accept ? dbh_pkg::CMD_ACCEPT : dbh_pkg::CMD_NONE;
            S_MIX1:  o_cmd = dbh_pkg::CMD_MUL_K;
            S_MIX2:  o_cmd = dbh_pkg::CMD_MUL_K2;
            S_MIX3:  o_cmd = dbh_pkg::CMD_MUL_ACC;
            S_MIX4:  o_cmd = dbh_pkg::CMD_MIX_DONE;
            S_TAIL:  o_cmd = dbh_pkg::CMD_TAIL;
            S_FIN:   o_cmd = dbh_pkg::CMD_FIN;
            S_OUT:   o_cmd = out_free ? dbh_pkg::CMD_OUT : dbh_pkg::CMD_NONE;
            default: o_cmd = dbh_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result, or drop the one just taken
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        priority if (i_status.empty) begin
                            r_state <= S_TAIL;
                        end else if (i_status.word_done) begin
                            r_last  <= i_status.last;
                            r_state <= S_MIX1;
                        end else if (i_status.last) begin
                            r_state <= S_TAIL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MIX1: r_state <= S_MIX2;
                S_MIX2: r_state <= S_MIX3;
                S_MIX3: r_state <= S_MIX4;
                S_MIX4: r_state <= r_last ? S_TAIL : S_IDLE;
                S_TAIL: r_state <= S_FIN;
                S_FIN:  r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/dual_byte_hash_64.sv
// Top level of the dual byte hash block: 64-bit key hash from a byte stream.
`timescale 1ns / 1ps

// Usage:
//   i_key is a valid/ready sink taking one key byte per transaction. The
//   first transaction of a key also carries the key length; later lengths
//   are ignored. A first transaction with length zero produces a result at
//   once and its byte is dropped.
//   o_hash is a valid/ready source giving one 64-bit transaction per key:
//   bits 63:32 one-at-a-time hash, bits 31:0 endian-neutral word hash.
//   i_cfg_wr_en/i_cfg_wr_data write the word-hash seed; write only while idle.
// Byte intake:
//   A byte that does not complete a 4-byte word leaves i_key ready for the
//   next byte. A byte that completes a word holds i_key off while the word
//   mix, states S_MIX1 to S_MIX4, runs three multiplies in turn through one
//   shared 32x32 constant multiplier.
// Finalization:
//   After the last byte (and the word mix, if it completes a word), states
//   S_TAIL, S_FIN, S_OUT finalize; the result is valid the cycle after S_OUT.
// Reset and stalls:
//   Reset restores the default seed and waits for a first byte. The result
//   sits in an output register; the next key's bytes are accepted while it
//   waits, and finalization holds until the register is free.

module dual_byte_hash_64 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,
    dbh_byte_if.sink     i_key,
    dbh_hash_if.source   o_hash
);

    dbh_pkg::t_cmd    cmd;
    dbh_pkg::t_status status;

    dbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key.valid),
        .i_out_ready (o_hash.ready),
        .i_status    (status),
        .o_in_ready  (i_key.ready),
        .o_out_valid (o_hash.valid),
        .o_cmd       (cmd)
    );

    dbh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .i_byte        (i_key.byte_value),
        .i_len         (i_key.key_length),
        .o_status      (status),
        .o_hash        (o_hash.hash_value)
    );

endmodule

// File: tb/tb_dual_byte_hash_64.sv
// Self-checking testbench for the dual byte hash block: directed table, then random keys.
`timescale 1ns / 1ps

module tb_dual_byte_hash_64;

    // Bound on the whole run.
    localparam int CYCLE_LIMIT  = 500000;
    // Finalization plus a word mix, with margin: settle time before a seed write
    // and at the end of the run.
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 290;

    typedef enum logic [0:0] {
        ROW_SEED,
        ROW_BYTE
    } t_row_kind;

    // One row of the directed table: a seed write or one key byte.
    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] value;     // seed for ROW_SEED, byte in [7:0] for ROW_BYTE
        logic [31:0] len;       // key length, only looked at on the first byte of a key
        logic        has_hash;  // expected hash typed in below
        logic [63:0] hash;
    } t_dir_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } t_stall_mode;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    dbh_byte_if key_if ();
    dbh_hash_if hash_if ();

    dual_byte_hash_64 uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_key         (key_if.sink),
        .o_hash        (hash_if.source)
    );

    // 2 ns period, low half first so every time-zero value settles before an edge.
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Hash predictor: its own copy of the seed and the running state.
    // ------------------------------------------------------------------
    logic [31:0] seed_shadow = dbh_pkg::SEED_RESET;
    logic [31:0] word_acc    = '0;   // running word hash
    logic [31:0] oaat_acc    = '0;   // running one-at-a-time hash
    logic [23:0] tail_bytes  = '0;   // bytes of the partial word, first byte lowest
    logic [1:0]  tail_count  = '0;   // how many bytes tail_bytes holds
    logic [31:0] bytes_to_go = '0;
    logic        key_open    = 1'b0; // a key is being taken in

    logic [63:0] expected_hashes [$];
    int          mismatch_count = 0;

    function automatic logic [31:0] word_finish(logic [31:0] h);
        h = h ^ (h >> 13);
        h = h * dbh_pkg::MUR_MUL;
        h = h ^ (h >> 15);
        return h;
    endfunction

    function automatic logic [31:0] oaat_finish(logic [31:0] h);
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    // Absorb one key byte; returns 1 with the 64-bit hash when the byte closes a key.
    function automatic bit hash_absorb_byte(input logic [7:0] b, input logic [31:0] len,
                                            output logic [63:0] hv);
        logic [31:0] h;
        logic [31:0] k;
        hv = '0;
        if (!key_open) begin
            // Empty key: seed alone, finalized; the byte is dropped.
            if (len == 32'd0) begin
                hv = {32'd0, word_finish(seed_shadow)};
                return 1'b1;
            end
            word_acc    = seed_shadow ^ len;
            oaat_acc    = '0;
            tail_bytes  = '0;
            tail_count  = '0;
            bytes_to_go = len;
            key_open    = 1'b1;
        end

        h = oaat_acc + {24'd0, b};
        h = h + (h << 10);
        h = h ^ (h >> 6);
        oaat_acc = h;

        if (tail_count != 2'd3) begin
            tail_bytes[tail_count*8 +: 8] = b;
            tail_count = tail_count + 2'd1;
        end else begin
            k = {b, tail_bytes};
            k = k * dbh_pkg::MUR_MUL;
            k = k ^ (k >> 24);
            k = k * dbh_pkg::MUR_MUL;
            word_acc   = (word_acc * dbh_pkg::MUR_MUL) ^ k;
            tail_bytes = '0;
            tail_count = '0;
        end

        bytes_to_go = bytes_to_go - 32'd1;
        if (bytes_to_go != 32'd0)
            return 1'b0;

        // Fold in a 1 to 3 byte tail, then finalize both halves.
        h = word_acc;
        if (tail_count != 2'd0)
            h = (h ^ {8'd0, tail_bytes}) * dbh_pkg::MUR_MUL;
        hv = {oaat_finish(oaat_acc), word_finish(h)};
        word_acc   = '0;
        oaat_acc   = '0;
        tail_bytes = '0;
        tail_count = '0;
        key_open   = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted hash against the oldest expectation.
    // ------------------------------------------------------------------
    logic [63:0] want_hash;

    always @(posedge clk) begin
        if (rst_n && hash_if.valid && hash_if.ready) begin
            if (expected_hashes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected hash, expected none actual %h",
                         $time, hash_if.hash_value);
            end else begin
                want_hash = expected_hashes.pop_front();
                if (hash_if.hash_value !== want_hash) begin
                    mismatch_count++;
                    $display("%0t: hash_value mismatch, expected %h actual %h",
                             $time, want_hash, hash_if.hash_value);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    int cycle_count = 0;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d hashes outstanding",
                     $time, expected_hashes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready follows a random stall mode, picked anew when mode_left runs out;
    // a hold request from the stimulus side drops ready so that the block backs up.
    // ------------------------------------------------------------------
    bit hold_req = 1'b0;

    initial begin : result_sink
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        logic [7:0]  pat;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        pat       = '0;
        hash_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = $urandom_range(250, 400);
            end
            if (hold_left > 0) begin
                hold_left--;
                hash_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 64);
                    pat       = 8'($urandom_range(0, 255));
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  hash_if.ready <= 1'b1;
                    STALL_LIGHT: hash_if.ready <= ($urandom_range(0, 3) != 0);
                    STALL_HEAVY: hash_if.ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        hash_if.ready <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Key side: bursts of random length with random gaps, unless steady_send.
    // ------------------------------------------------------------------
    int burst_left  = 0;
    bit steady_send = 1'b0;

    // Offer one byte, hold it until taken, then predict. A typed-in hash, where
    // given, stands in place of the predicted one.
    task automatic send_key_byte(input logic [7:0] b, input logic [31:0] len,
                                 input bit has_hash, input logic [63:0] typed_hash);
        logic [63:0] hv;
        int          gap;
        if (!steady_send) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(1, 5);
                repeat (gap) begin
                    @(negedge clk);
                    key_if.valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge clk);
        key_if.valid      <= 1'b1;
        key_if.byte_value <= b;
        key_if.key_length <= len;
        do
            @(posedge clk);
        while (!key_if.ready);
        if (hash_absorb_byte(b, len, hv))
            expected_hashes.push_back(has_hash ? typed_hash : hv);
    endtask

    // Drop valid, wait for every expected hash, then let the block settle.
    task automatic wait_drained();
        @(negedge clk);
        key_if.valid <= 1'b0;
        while (expected_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        seed_shadow = seed;
    endtask

    // Mostly short keys, a few empty ones, now and then a long one.
    function automatic int pick_key_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 0;
        else if (r < 60)
            return $urandom_range(1, 8);
        else if (r < 90)
            return $urandom_range(9, 24);
        return $urandom_range(25, 80);
    endfunction

    // One seed setting, then random keys; lengths on later bytes are random noise
    // the block must ignore.
    task automatic run_phase(input logic [31:0] seed, input bit long_hold);
        int sent;
        int len;
        int i;
        sent = 0;
        write_seed(seed);
        if (long_hold) begin
            // Keep offering bytes while the result side holds off.
            hold_req    = 1'b1;
            steady_send = 1'b1;
        end
        while (sent < PHASE_ITEMS) begin
            len = pick_key_len();
            if (!long_hold || sent > 120)
                steady_send = ($urandom_range(0, 4) == 0);
            if (len == 0) begin
                send_key_byte(8'($urandom_range(0, 255)), 32'd0, 1'b0, '0);
                sent++;
            end else begin
                for (i = 0; i < len; i++) begin
                    send_key_byte(8'($urandom_range(0, 255)),
                                  (i == 0) ? 32'(len) : 32'($urandom()), 1'b0, '0);
                    sent++;
                end
            end
        end
        steady_send = 1'b0;
    endtask

    t_dir_row dir_rows [22];

    initial begin : key_source
        int i;
        key_if.valid      = 1'b0;
        key_if.byte_value = '0;
        key_if.key_length = '0;

        // Directed table: empty key on the reset seed, keys of 1 to 5 bytes with
        // extreme bytes and ignored lengths (0, 1, 2^31, ~0) on later bytes, then
        // empty keys on seed zero (hash zero), 0- and 1-byte keys on seed all-ones.
        dir_rows = '{
            '{ROW_BYTE, 32'h0000_00A5, 32'd0,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_00FF, 32'd1,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_0000, 32'd2,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_0080, 32'hFFFF_FFFF,  1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_0001, 32'd3,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_007F, 32'd0,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_00FE, 32'd0,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_0012, 32'd4,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_0034, 32'h8000_0000,  1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_0056, 32'd1,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_0078, 32'd0,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_00FF, 32'd5,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_00FF, 32'd0,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_00FF, 32'hFFFF_FFFF,  1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_00FF, 32'd0,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_00FF, 32'd0,          1'b0, 64'd0},
            '{ROW_SEED, 32'h0000_0000, 32'd0,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_00FF, 32'd0,          1'b1, 64'd0},
            '{ROW_BYTE, 32'h0000_0000, 32'd0,          1'b1, 64'd0},
            '{ROW_SEED, 32'hFFFF_FFFF, 32'd0,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_005A, 32'd0,          1'b0, 64'd0},
            '{ROW_BYTE, 32'h0000_0000, 32'd1,          1'b0, 64'd0}
        };

        // Synchronous reset, released at a falling edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_SEED)
                write_seed(dir_rows[i].value);
            else
                send_key_byte(dir_rows[i].value[7:0], dir_rows[i].len,
                              dir_rows[i].has_hash, dir_rows[i].hash);
        end

        // Random phases, each under its own seed; the second one backs up the block.
        run_phase($urandom(), 1'b0);
        run_phase(32'h0000_0000, 1'b1);
        run_phase(32'hFFFF_FFFF, 1'b0);
        run_phase(dbh_pkg::SEED_RESET, 1'b0);
        run_phase($urandom(), 1'b0);
        run_phase($urandom(), 1'b0);

        // Open a key of the largest length and feed part of it: it can never
        // close in this run, so no hash may come out.
        wait_drained();
        send_key_byte(8'($urandom_range(0, 255)), 32'hFFFF_FFFF, 1'b0, '0);
        for (i = 0; i < 40; i++)
            send_key_byte(8'($urandom_range(0, 255)), 32'($urandom()), 1'b0, '0);
        wait_drained();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: dual_byte_hash_64.f
rtl/dbh_pkg.sv
rtl/dbh_if.sv
rtl/dbh_datapath.sv
rtl/dbh_ctrl.sv
rtl/dual_byte_hash_64.sv
tb/tb_dual_byte_hash_64.sv
